// File: hw/rtl/pll_pkg.sv
// Shared constants, register codes and types for the peak limiter.
package pll_pkg;

  localparam int NUM_IN_CH        = 8;
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int CEIL_BITS     = 24;
  localparam int NCH_BITS      = 4;
  localparam int STEP_BITS     = 16;
  localparam int PEAK_BITS     = 24;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int REPORT_BITS   = 2;

  localparam int FLOOR_DIV = 1000000;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLED      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_CH    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_STEP = 2'd3;

  localparam logic [REPORT_BITS-1:0] REPORT_NONE = 2'd0;
  localparam logic [REPORT_BITS-1:0] REPORT_OUT  = 2'd1;
  localparam logic [REPORT_BITS-1:0] REPORT_BOTH = 2'd2;

  localparam logic                 RST_ENABLED      = 1'b1;
  localparam logic [CEIL_BITS-1:0] RST_CEILING      = 24'd8388608;
  localparam logic [NCH_BITS-1:0]  RST_ACTIVE_CH    = 4'd2;
  localparam logic [STEP_BITS-1:0] RST_RELEASE_STEP = 16'd671;

  typedef struct packed {
    logic load;
    logic mul_en;
  } lane_ctrl_t;

endpackage

// File: hw/rtl/pll_lane.sv
// One channel lane: sample capture, magnitude, gain product and sign restore.
module pll_lane #(
  parameter int SAMPLE_BITS = pll_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  pll_pkg::lane_ctrl_t           ctrl,
  input  logic                          active,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0]        gain,
  output logic [SAMPLE_BITS-1:0]        mag,
  output logic [SAMPLE_BITS-1:0]        scaled,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_BITS = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0]        smp_u;
  logic [PROD_BITS-1:0]          prod;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      smp <= active ? sample : '0;
    end
    if (ctrl.mul_en) begin
      scaled <= prod[PROD_BITS-2 -: SAMPLE_BITS];
    end
  end

  assign smp_u  = smp;
  assign mag    = smp[SAMPLE_BITS-1] ? (~smp_u + 1'b1) : smp_u;
  assign prod   = PROD_BITS'(mag) * PROD_BITS'(gain);
  assign result = smp[SAMPLE_BITS-1] ? $signed(~scaled + 1'b1) : $signed(scaled);

endmodule

// File: hw/rtl/pll_merge.sv
// Largest of the lane values.
module pll_merge #(
  parameter int LANES = pll_pkg::DEF_MAX_CHANNELS,
  parameter int WIDTH = pll_pkg::DEF_SAMPLE_BITS
) (
  input  logic [WIDTH-1:0] vals [LANES],
  output logic [WIDTH-1:0] max_val
);

  always_comb begin
    max_val = '0;
    for (int k = 0; k < LANES; k++) begin
      if (vals[k] > max_val) begin
        max_val = vals[k];
      end
    end
  end

endmodule

// File: hw/rtl/pll_div.sv
// Restoring divider, one quotient bit per cycle, for dividend below divisor.
module pll_div #(
  parameter int SAMPLE_BITS = pll_pkg::DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] dividend,
  input  logic [SAMPLE_BITS-1:0] divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quotient
);

  localparam int STEPS    = SAMPLE_BITS - 1;
  localparam int CNT_BITS = $clog2(SAMPLE_BITS);

  logic                   running;
  logic [CNT_BITS-1:0]    cnt;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = ~diff[SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_BITS'(STEPS - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= '0;
    end else if (running) begin
      rem      <= ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      quotient <= {quotient[SAMPLE_BITS-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/peak_limiter_linear_release_core.sv
// Peak limiter top level: control sequencer, gain state, peak meters, result register.
// Steps: accept, peak capture, ceiling check, a bit-serial gain divide (only when
//   enabled and the frame peak is over the ceiling), gain update, lane multiply, result.
// One frame is in flight at a time: the input stalls until its result is registered.
// A finished result waits in the output register while the next frame is taken.
// Reset (rst, synchronous): registers to their defaults, gain to unity, peak meters to zero.
module peak_limiter_linear_release_core #(
  parameter int MAX_CHANNELS = pll_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = pll_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pll_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pll_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample_0,
  input  logic signed [SAMPLE_BITS-1:0]       sample_1,
  input  logic signed [SAMPLE_BITS-1:0]       sample_2,
  input  logic signed [SAMPLE_BITS-1:0]       sample_3,
  input  logic signed [SAMPLE_BITS-1:0]       sample_4,
  input  logic signed [SAMPLE_BITS-1:0]       sample_5,
  input  logic signed [SAMPLE_BITS-1:0]       sample_6,
  input  logic signed [SAMPLE_BITS-1:0]       sample_7,
  input  logic                                buffer_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_0,
  output logic signed [SAMPLE_BITS-1:0]       out_1,
  output logic signed [SAMPLE_BITS-1:0]       out_2,
  output logic signed [SAMPLE_BITS-1:0]       out_3,
  output logic signed [SAMPLE_BITS-1:0]       out_4,
  output logic signed [SAMPLE_BITS-1:0]       out_5,
  output logic signed [SAMPLE_BITS-1:0]       out_6,
  output logic signed [SAMPLE_BITS-1:0]       out_7,
  output logic                                frame_last,
  output logic [pll_pkg::PEAK_BITS-1:0]       peak_in,
  output logic [pll_pkg::PEAK_BITS-1:0]       peak_out,
  output logic [pll_pkg::REPORT_BITS-1:0]     report_kind
);

  localparam int NCH   = pll_pkg::NUM_IN_CH;
  localparam int SB    = SAMPLE_BITS;
  localparam int CMP_BITS = (SB > pll_pkg::CEIL_BITS) ? SB : pll_pkg::CEIL_BITS;
  localparam int SUM_BITS = ((SB > pll_pkg::STEP_BITS) ? SB : pll_pkg::STEP_BITS) + 1;
  localparam logic [SB-1:0] UNITY    = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] IN_FLOOR = SB'((64'd1 << (SB - 1)) / pll_pkg::FLOOR_DIV);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PEAK  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  logic                               enabled;
  logic [pll_pkg::CEIL_BITS-1:0]      ceiling;
  logic [pll_pkg::NCH_BITS-1:0]       active_channels;
  logic [pll_pkg::STEP_BITS-1:0]      release_step;

  logic [SB-1:0] gain;
  logic [SB-1:0] target;
  logic [SB-1:0] peak;
  logic [SB-1:0] in_peak_acc;
  logic [SB-1:0] out_peak_acc;
  logic [SB-1:0] out_peak_new;
  logic          last;

  logic signed [SB-1:0] samples [NCH];
  logic signed [SB-1:0] lane_res [NCH];
  logic signed [SB-1:0] out_r [NCH];
  logic [SB-1:0]        lane_mag [MAX_CHANNELS];
  logic [SB-1:0]        lane_scaled [MAX_CHANNELS];
  logic [SB-1:0]        frame_peak;
  logic [SB-1:0]        frame_opeak;

  pll_pkg::lane_ctrl_t lane_ctrl;

  logic                div_start;
  logic                div_done;
  logic [SB-1:0]       div_q;
  logic                over;
  logic [SUM_BITS-1:0] gain_sum;
  logic [SB-1:0]       gain_rel;
  logic                out_free;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  assign out_0 = out_r[0];
  assign out_1 = out_r[1];
  assign out_2 = out_r[2];
  assign out_3 = out_r[3];
  assign out_4 = out_r[4];
  assign out_5 = out_r[5];
  assign out_6 = out_r[6];
  assign out_7 = out_r[7];

  assign in_stall = (state != S_IDLE);

  always_comb begin
    lane_ctrl.load   = in_valid && (state == S_IDLE);
    lane_ctrl.mul_en = (state == S_MUL);
  end

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    if (k < MAX_CHANNELS) begin : g_used
      logic active;
      assign active = (k == 0) ||
                      (pll_pkg::NCH_BITS'(k) < active_channels);
      pll_lane #(.SAMPLE_BITS(SB)) u_lane (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .active (active),
        .sample (samples[k]),
        .gain   (gain),
        .mag    (lane_mag[k]),
        .scaled (lane_scaled[k]),
        .result (lane_res[k])
      );
    end else begin : g_unused
      assign lane_res[k] = '0;
    end
  end

  pll_merge #(.LANES(MAX_CHANNELS), .WIDTH(SB)) u_in_merge (
    .vals    (lane_mag),
    .max_val (frame_peak)
  );

  pll_merge #(.LANES(MAX_CHANNELS), .WIDTH(SB)) u_out_merge (
    .vals    (lane_scaled),
    .max_val (frame_opeak)
  );

  assign over      = CMP_BITS'(peak) > CMP_BITS'(ceiling);
  assign div_start = (state == S_CHECK) && enabled && over;

  pll_div #(.SAMPLE_BITS(SB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (SB'(ceiling)),
    .divisor  (peak),
    .done     (div_done),
    .quotient (div_q)
  );

  assign gain_sum     = SUM_BITS'(gain) + SUM_BITS'(release_step);
  assign gain_rel     = (gain_sum > SUM_BITS'(UNITY)) ? UNITY : gain_sum[SB-1:0];
  assign out_peak_new = (frame_opeak > out_peak_acc) ? frame_opeak : out_peak_acc;
  assign out_free     = !out_valid || !out_stall;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= pll_pkg::RST_ENABLED;
      ceiling         <= pll_pkg::RST_CEILING;
      active_channels <= pll_pkg::RST_ACTIVE_CH;
      release_step    <= pll_pkg::RST_RELEASE_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        pll_pkg::REG_ENABLED:      enabled         <= cfg_data[0];
        pll_pkg::REG_CEILING:      ceiling         <= cfg_data[pll_pkg::CEIL_BITS-1:0];
        pll_pkg::REG_ACTIVE_CH:    active_channels <= cfg_data[pll_pkg::NCH_BITS-1:0];
        pll_pkg::REG_RELEASE_STEP: release_step    <= cfg_data[pll_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and gain / meter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      gain         <= UNITY;
      in_peak_acc  <= '0;
      out_peak_acc <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= div_start ? S_DIV : S_GAIN;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (enabled) begin
            if (target < gain) begin
              gain <= target;
            end else if (gain < UNITY) begin
              gain <= gain_rel;
            end
            if (peak > in_peak_acc) begin
              in_peak_acc <= peak;
            end
          end else begin
            gain <= UNITY;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (last) begin
              in_peak_acc  <= '0;
              out_peak_acc <= '0;
            end else begin
              out_peak_acc <= out_peak_new;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (lane_ctrl.load) begin
      last <= buffer_end;
    end
    if (state == S_PEAK) begin
      peak <= frame_peak;
    end
    if (state == S_CHECK) begin
      target <= UNITY;
    end else if (state == S_DIV && div_done) begin
      target <= div_q;
    end
    if (state == S_DONE && out_free) begin
      out_r      <= lane_res;
      frame_last <= last;
      if (last && enabled && in_peak_acc > IN_FLOOR) begin
        peak_in     <= pll_pkg::PEAK_BITS'(in_peak_acc);
        peak_out    <= pll_pkg::PEAK_BITS'(out_peak_new);
        report_kind <= pll_pkg::REPORT_BOTH;
      end else if (last && !enabled) begin
        peak_in     <= '0;
        peak_out    <= pll_pkg::PEAK_BITS'(out_peak_new);
        report_kind <= pll_pkg::REPORT_OUT;
      end else begin
        peak_in     <= '0;
        peak_out    <= '0;
        report_kind <= pll_pkg::REPORT_NONE;
      end
    end
  end

endmodule

// File: hw/rtl/pll_checker.sv
// Port-level checks for the peak limiter, bound to the top level.
module pll_checker #(
  parameter int SAMPLE_BITS = pll_pkg::DEF_SAMPLE_BITS
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [SAMPLE_BITS-1:0]    out_0,
  input logic                             frame_last,
  input logic [pll_pkg::PEAK_BITS-1:0]    peak_in,
  input logic [pll_pkg::PEAK_BITS-1:0]    peak_out,
  input logic [pll_pkg::REPORT_BITS-1:0]  report_kind
);

  // one frame in flight: taking a beat makes the input busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  a_report_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> report_kind == pll_pkg::REPORT_NONE)
    else $error("peak report on a frame that is not last");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_kind == pll_pkg::REPORT_NONE |-> peak_in == '0 && peak_out == '0)
    else $error("peaks nonzero without report");

  a_out_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_kind == pll_pkg::REPORT_OUT |-> peak_in == '0)
    else $error("input peak shown in output-only report");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_0) && $stable(report_kind))
    else $error("stalled output beat changed");

endmodule

bind peak_limiter_linear_release_core pll_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pll_checker (.*);
